### sv/pdvi_pkg.sv
// Package for the deadzone PID controller: sequencer states, register indexes and saturation helpers.
package pdvi_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DZ,
        ST_INT,
        ST_MUL_G,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_F1,
        ST_MUL_F2,
        ST_FILT,
        ST_OUT
    } t_state;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LOWER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_UPPER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd7;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Saturate a 33-bit difference to the signed 32-bit range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < 33'(S32_MIN)) begin
            return S32_MIN;
        end
        return 32'(v);
    endfunction

    // Shift a Q32.32 value down to Q16.16 (floor) and saturate to 32 bits.
    function automatic logic signed [31:0] sat_shr16(input logic signed [66:0] v);
        logic signed [50:0] s;
        s = 51'(v >>> 16);
        if (s > 51'(S32_MAX)) begin
            return S32_MAX;
        end else if (s < 51'(S32_MIN)) begin
            return S32_MIN;
        end
        return 32'(s);
    endfunction

    // Symmetric clamp to +-lim.
    function automatic logic signed [31:0] clamp_sym(input logic signed [34:0] v,
                                                     input logic [30:0] lim);
        logic signed [34:0] l;
        l = $signed({4'b0000, lim});
        if (v > l) begin
            return 32'(l);
        end else if (v < -l) begin
            return 32'(-l);
        end
        return 32'(v);
    endfunction

endpackage

### sv/pid_deadzone_variable_integral.sv
// PID controller with deadzone, variable-speed integral and filtered output-change derivative.
//
// Usage: a request on the input channel (i_in_valid, o_in_stall) carries a target
// and a measurement in signed Q16.16. The block answers each request with exactly
// one drive value on the output channel (o_out_valid, i_out_stall).
// The user writes gains, deadzone, integral thresholds and limits through the plain write
// port (i_cfg_we, i_cfg_idx, i_cfg_wdata) only while the block is idle; nothing enforces it.
//
// After acceptance a request steps through ERR, DZ, INT, MUL_P, MUL_I, MUL_F1, MUL_F2,
// FILT and OUT to the result register. When the error is inside the graded integration
// band, MUL_G and the 32-step restoring divider that scales the integral increment come
// between INT and MUL_P. The next request is accepted only after the result is loaded.
// All products go through one shared 33x33 multiplier with a registered result, stepped
// by the state machine. o_in_stall is high from acceptance until the result is loaded.
// The result register holds its value while i_out_stall is high; a new request is accepted
// meanwhile, and its result waits until the register is free. Synchronous reset clears the
// state machine, configuration, integrator and filter state; datapath registers are not reset.
module pid_deadzone_variable_integral #(
    parameter int unsigned FILTER_COEF = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [31:0]                  i_target,
    input  logic signed [31:0]                  i_measured,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_drive,
    input  logic                                i_cfg_we,
    input  logic [pdvi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                         i_cfg_wdata
);

    localparam logic signed [32:0] COEF_NEW = 33'(FILTER_COEF);
    localparam logic signed [32:0] COEF_OLD = 33'(65536 - FILTER_COEF);

    pdvi_pkg::t_state r_state, n_state;

    // configuration
    logic signed [31:0] r_kp, r_ki, r_kd;
    logic [30:0]        r_dead_band, r_integ_lower, r_integ_upper, r_integ_limit, r_out_limit;

    // controller state
    logic signed [31:0] r_prev_err, r_integ, r_out_now, r_out_before, r_df;

    // working registers
    logic signed [31:0] r_tgt, r_meas, r_err, r_diff, r_dm, r_t, r_pterm, r_iterm;
    logic [30:0]        r_gap, r_dvs;
    logic signed [65:0] r_prod, r_acc;
    logic [31:0]        r_rem, r_quo;
    logic [4:0]         r_cnt;
    logic               r_neg;
    logic               r_out_valid;
    logic signed [31:0] r_drive;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    // combinational helpers
    logic [31:0]        mag;
    logic               in_lower, in_upper;
    logic signed [31:0] t_now;
    logic signed [32:0] e_sum;
    logic [31:0]        rem_sh;
    logic               q_bit;
    logic [63:0]        abs_prod;
    logic signed [32:0] inc;
    logic               out_free;

    assign mag      = r_err[31] ? 32'(-r_err) : 32'(r_err);
    assign in_lower = mag < {1'b0, r_integ_lower};
    assign in_upper = mag < {1'b0, r_integ_upper};
    assign e_sum    = 33'(r_err) + 33'(r_prev_err);
    assign t_now    = 32'(e_sum >>> 1);
    assign rem_sh   = {r_rem[30:0], r_quo[31]};
    assign q_bit    = rem_sh >= {1'b0, r_dvs};
    assign abs_prod = r_prod[65] ? 64'(-r_prod) : 64'(r_prod);
    assign inc      = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign out_free = !r_out_valid || !i_out_stall;

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            pdvi_pkg::ST_DZ: begin
                mul_a = 33'(r_kd);
                mul_b = 33'(r_diff);
            end
            pdvi_pkg::ST_MUL_G: begin
                mul_a = 33'(r_t);
                mul_b = $signed({2'b00, r_gap});
            end
            pdvi_pkg::ST_MUL_P: begin
                mul_a = 33'(r_kp);
                mul_b = 33'(r_err);
            end
            pdvi_pkg::ST_MUL_I: begin
                mul_a = 33'(r_ki);
                mul_b = 33'(r_integ);
            end
            pdvi_pkg::ST_MUL_F1: begin
                mul_a = 33'(r_dm);
                mul_b = COEF_NEW;
            end
            pdvi_pkg::ST_MUL_F2: begin
                mul_a = 33'(r_df);
                mul_b = COEF_OLD;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdvi_pkg::ST_IDLE:     if (i_in_valid) n_state = pdvi_pkg::ST_ERR;
            pdvi_pkg::ST_ERR:      n_state = pdvi_pkg::ST_DZ;
            pdvi_pkg::ST_DZ:       n_state = pdvi_pkg::ST_INT;
            pdvi_pkg::ST_INT: begin
                if (!in_lower && in_upper) begin
                    n_state = pdvi_pkg::ST_MUL_G;
                end else begin
                    n_state = pdvi_pkg::ST_MUL_P;
                end
            end
            pdvi_pkg::ST_MUL_G:    n_state = pdvi_pkg::ST_DIV_INIT;
            pdvi_pkg::ST_DIV_INIT: n_state = pdvi_pkg::ST_DIV_STEP;
            pdvi_pkg::ST_DIV_STEP: if (r_cnt == 5'd31) n_state = pdvi_pkg::ST_DIV_END;
            pdvi_pkg::ST_DIV_END:  n_state = pdvi_pkg::ST_MUL_P;
            pdvi_pkg::ST_MUL_P:    n_state = pdvi_pkg::ST_MUL_I;
            pdvi_pkg::ST_MUL_I:    n_state = pdvi_pkg::ST_MUL_F1;
            pdvi_pkg::ST_MUL_F1:   n_state = pdvi_pkg::ST_MUL_F2;
            pdvi_pkg::ST_MUL_F2:   n_state = pdvi_pkg::ST_FILT;
            pdvi_pkg::ST_FILT:     n_state = pdvi_pkg::ST_OUT;
            pdvi_pkg::ST_OUT:      if (out_free) n_state = pdvi_pkg::ST_IDLE;
            default:               n_state = pdvi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdvi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= '0;
            r_ki          <= '0;
            r_kd          <= '0;
            r_dead_band   <= '0;
            r_integ_lower <= '0;
            r_integ_upper <= '0;
            r_integ_limit <= '0;
            r_out_limit   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdvi_pkg::CFG_KP:          r_kp          <= $signed(i_cfg_wdata);
                pdvi_pkg::CFG_KI:          r_ki          <= $signed(i_cfg_wdata);
                pdvi_pkg::CFG_KD:          r_kd          <= $signed(i_cfg_wdata);
                pdvi_pkg::CFG_DEAD_BAND:   r_dead_band   <= i_cfg_wdata[30:0];
                pdvi_pkg::CFG_INTEG_LOWER: r_integ_lower <= i_cfg_wdata[30:0];
                pdvi_pkg::CFG_INTEG_UPPER: r_integ_upper <= i_cfg_wdata[30:0];
                pdvi_pkg::CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_wdata[30:0];
                pdvi_pkg::CFG_OUT_LIMIT:   r_out_limit   <= i_cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state and loop counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err   <= '0;
            r_integ      <= '0;
            r_out_now    <= '0;
            r_out_before <= '0;
            r_df         <= '0;
            r_cnt        <= '0;
        end else begin
            unique case (r_state)
                pdvi_pkg::ST_INT: begin
                    r_prev_err <= r_err;
                    if (in_lower) begin
                        r_integ <= pdvi_pkg::clamp_sym(35'(r_integ) + 35'(t_now),
                                                       r_integ_limit);
                    end else if (!in_upper) begin
                        r_integ <= '0;
                    end
                end
                pdvi_pkg::ST_DIV_INIT: r_cnt <= '0;
                pdvi_pkg::ST_DIV_STEP: r_cnt <= r_cnt + 5'd1;
                pdvi_pkg::ST_DIV_END: begin
                    r_integ <= pdvi_pkg::clamp_sym(35'(r_integ) + 35'(inc), r_integ_limit);
                end
                pdvi_pkg::ST_FILT: begin
                    r_df <= pdvi_pkg::sat_shr16(67'(r_acc) + 67'(r_prod));
                end
                pdvi_pkg::ST_OUT: begin
                    if (out_free) begin
                        r_out_before <= r_out_now;
                        r_out_now    <= pdvi_pkg::clamp_sym(35'(r_pterm) + 35'(r_iterm)
                                                            + 35'(r_df), r_out_limit);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working datapath registers; no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            pdvi_pkg::ST_IDLE: begin
                r_tgt  <= i_target;
                r_meas <= i_measured;
            end
            pdvi_pkg::ST_ERR: begin
                r_err  <= pdvi_pkg::sat33(33'(r_tgt) - 33'(r_meas));
                r_diff <= pdvi_pkg::sat33(33'(r_out_now) - 33'(r_out_before));
            end
            pdvi_pkg::ST_DZ: begin
                if (mag < {1'b0, r_dead_band}) begin
                    r_err <= '0;
                end
            end
            pdvi_pkg::ST_INT: begin
                r_dm  <= pdvi_pkg::sat_shr16(67'(r_prod));
                r_t   <= t_now;
                r_gap <= mag[30:0] - r_integ_lower;
                r_dvs <= r_integ_upper - r_integ_lower;
            end
            pdvi_pkg::ST_DIV_INIT: begin
                // |t| is at most 2^31 and the gap is below the divisor, so the top
                // word of the dividend is already below the divisor.
                r_neg <= r_prod[65];
                r_rem <= {1'b0, abs_prod[62:32]};
                r_quo <= abs_prod[31:0];
            end
            pdvi_pkg::ST_DIV_STEP: begin
                r_rem <= q_bit ? rem_sh - {1'b0, r_dvs} : rem_sh;
                r_quo <= {r_quo[30:0], q_bit};
            end
            pdvi_pkg::ST_MUL_I:  r_pterm <= pdvi_pkg::sat_shr16(67'(r_prod));
            pdvi_pkg::ST_MUL_F1: r_iterm <= pdvi_pkg::sat_shr16(67'(r_prod));
            pdvi_pkg::ST_MUL_F2: r_acc   <= r_prod;
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == pdvi_pkg::ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pdvi_pkg::ST_OUT && out_free) begin
            r_drive <= pdvi_pkg::clamp_sym(35'(r_pterm) + 35'(r_iterm) + 35'(r_df),
                                           r_out_limit);
        end
    end

    assign o_in_stall  = r_state != pdvi_pkg::ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the deadzone PID controller with a graded integral.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILTER_COEF   = 16384;
    localparam int ONE           = 65536;
    localparam int RANDOM_ITEMS  = 720;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int IDX_W         = pdvi_pkg::CFG_IDX_W;

    // Cycle-free model of the controller plus the queue of drive values still owed.
    class pid_tracker;
        longint kp, ki, kd;
        longint dead_band, integ_lower, integ_upper, integ_limit, out_limit;
        longint prev_err, integ_sum, out_now, out_before, deriv_filt;
        logic signed [31:0] pending_drive[$];
        int errors, n_requests, n_checked, n_dead, n_graded, n_cleared;

        function new();
            kp = 0; ki = 0; kd = 0;
            dead_band = 0; integ_lower = 0; integ_upper = 0;
            integ_limit = 0; out_limit = 0;
            prev_err = 0; integ_sum = 0; out_now = 0; out_before = 0; deriv_filt = 0;
            errors = 0; n_requests = 0; n_checked = 0;
            n_dead = 0; n_graded = 0; n_cleared = 0;
        endfunction

        function longint sat_s32(longint v);
            if (v > longint'(pdvi_pkg::S32_MAX)) begin
                return longint'(pdvi_pkg::S32_MAX);
            end else if (v < longint'(pdvi_pkg::S32_MIN)) begin
                return longint'(pdvi_pkg::S32_MIN);
            end
            return v;
        endfunction

        function longint limit_sym(longint v, longint lim);
            if (v > lim) begin
                return lim;
            end else if (v < -lim) begin
                return -lim;
            end
            return v;
        endfunction

        // Q16.16 product, floored and saturated.
        function longint qmul(longint a, longint b);
            return sat_s32((a * b) >>> 16);
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                pdvi_pkg::CFG_KP:          kp          = longint'($signed(data));
                pdvi_pkg::CFG_KI:          ki          = longint'($signed(data));
                pdvi_pkg::CFG_KD:          kd          = longint'($signed(data));
                pdvi_pkg::CFG_DEAD_BAND:   dead_band   = longint'(data[30:0]);
                pdvi_pkg::CFG_INTEG_LOWER: integ_lower = longint'(data[30:0]);
                pdvi_pkg::CFG_INTEG_UPPER: integ_upper = longint'(data[30:0]);
                pdvi_pkg::CFG_INTEG_LIMIT: integ_limit = longint'(data[30:0]);
                pdvi_pkg::CFG_OUT_LIMIT:   out_limit   = longint'(data[30:0]);
                default: ;
            endcase
        endfunction

        function void note_request(logic signed [31:0] target, logic signed [31:0] measured);
            longint last, err, mag, dm, half, inc, pterm, iterm, sum;
            last = prev_err;
            err = sat_s32(longint'(target) - longint'(measured));
            if ((err < 0 ? -err : err) < dead_band) begin
                err = 0;
                n_dead++;
            end
            prev_err = err;
            mag = (err < 0) ? -err : err;

            // The derivative acts on the output change of the two previous requests.
            dm = qmul(kd, sat_s32(out_now - out_before));

            half = (err + last) >>> 1;
            if (mag < integ_lower) begin
                integ_sum = limit_sym(integ_sum + half, integ_limit);
            end else if (mag < integ_upper) begin
                inc = (half * (mag - integ_lower)) / (integ_upper - integ_lower);
                integ_sum = limit_sym(integ_sum + inc, integ_limit);
                n_graded++;
            end else begin
                integ_sum = 0;
                n_cleared++;
            end

            pterm = qmul(kp, err);
            iterm = qmul(ki, integ_sum);
            deriv_filt = sat_s32((dm * FILTER_COEF + deriv_filt * (65536 - FILTER_COEF)) >>> 16);

            sum = pterm + iterm + deriv_filt;
            out_before = out_now;
            out_now = limit_sym(sum, out_limit);
            pending_drive.push_back(32'(out_now));
            n_requests++;
        endfunction

        function void check_drive(logic signed [31:0] got);
            logic signed [31:0] want;
            if (pending_drive.size() == 0) begin
                $error("drive: unexpected result %0d with no request outstanding", got);
                errors++;
                return;
            end
            want = pending_drive.pop_front();
            n_checked++;
            if (got !== want) begin
                $error("drive: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic signed [31:0] req_target = '0;
    logic signed [31:0] req_measured = '0;
    logic drv_valid;
    logic drv_stall = 1'b0;
    logic signed [31:0] drive;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_idx = '0;
    logic [31:0] cfg_wdata = '0;

    pid_tracker tracker;
    logic [31:0] cfg_val [8];
    bit valid_on = 1'b0;
    bit long_hold_req = 1'b0;
    int burst_left = 0;
    int gap_max = 4;
    int requests_sent = 0;
    int settings = 1;
    int cycles = 0;

    pid_deadzone_variable_integral #(
        .FILTER_COEF(FILTER_COEF)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_target    (req_target),
        .i_measured  (req_measured),
        .o_out_valid (drv_valid),
        .i_out_stall (drv_stall),
        .o_drive     (drive),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Both handshakes are sampled with the values that held just before the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && !req_stall) begin
                tracker.note_request(req_target, req_measured);
            end
            if (drv_valid && !drv_stall) begin
                tracker.check_drive(drive);
            end
        end
    end

    // Result side: open stretches, solid stalls, random flicker and one long hold-off.
    initial begin : result_side
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                drv_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end else begin
                n = $urandom_range(1, 30);
                case ($urandom_range(0, 3))
                    0: begin
                        drv_stall <= 1'b0;
                        repeat (n) @(posedge clk);
                    end
                    1: begin
                        drv_stall <= 1'b1;
                        repeat ($urandom_range(1, 12)) @(posedge clk);
                    end
                    default: begin
                        repeat (n) begin
                            drv_stall <= ($urandom_range(0, 2) == 0);
                            @(posedge clk);
                        end
                    end
                endcase
            end
        end
    end

    // Offers one request and returns at the edge that accepts it, then maybe idles.
    task automatic send_request(input logic [31:0] tgt, input logic [31:0] meas);
        int gap;
        req_valid <= 1'b1;
        valid_on = 1'b1;
        req_target <= tgt;
        req_measured <= meas;
        do @(posedge clk); while (req_stall !== 1'b0);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                req_valid <= 1'b0;
                valid_on = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits until every request has its drive value back and the block has gone quiet.
    task automatic settle();
        if (valid_on) begin
            req_valid <= 1'b0;
            valid_on = 1'b0;
        end
        while (tracker.n_checked != requests_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config();
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= IDX_W'(i);
            cfg_wdata <= cfg_val[i];
            tracker.set_reg(IDX_W'(i), cfg_val[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom();
        end
        return $urandom_range(0, 8 * ONE) - 4 * ONE;
    endfunction

    initial begin : stimulus
        int unsigned db, lo, up, il, ol;
        int random_sent, n_items, mode, phase;
        longint span, d;
        logic [31:0] tgt, meas;

        random_sent = 0;
        phase = 0;
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // All registers at reset: zero limits hold the drive at zero.
        send_request(pdvi_pkg::S32_MAX, pdvi_pkg::S32_MIN);
        send_request(100 * ONE, 3 * ONE);
        settle();

        // Moderate gains; the deadzone word carries a stray top bit that must be dropped.
        cfg_val[pdvi_pkg::CFG_KP]          = ONE;
        cfg_val[pdvi_pkg::CFG_KI]          = ONE / 2;
        cfg_val[pdvi_pkg::CFG_KD]          = -(ONE / 4);
        cfg_val[pdvi_pkg::CFG_DEAD_BAND]   = 32'h8000_8000;
        cfg_val[pdvi_pkg::CFG_INTEG_LOWER] = 2 * ONE;
        cfg_val[pdvi_pkg::CFG_INTEG_UPPER] = 10 * ONE;
        cfg_val[pdvi_pkg::CFG_INTEG_LIMIT] = 8 * ONE;
        cfg_val[pdvi_pkg::CFG_OUT_LIMIT]   = 50 * ONE;
        write_config();
        send_request(0, 0);
        send_request(ONE / 4, 0);
        send_request(ONE / 2, 0);
        send_request(3 * ONE / 2, 0);
        send_request(0, 3 * ONE / 2);
        send_request(2 * ONE, 0);
        send_request(5 * ONE, 0);
        send_request(0, 7 * ONE);
        send_request(10 * ONE, 0);
        repeat (6) send_request(19 * ONE / 10, 0);
        send_request(pdvi_pkg::S32_MAX, pdvi_pkg::S32_MIN);
        send_request(pdvi_pkg::S32_MIN, pdvi_pkg::S32_MAX);
        settle();

        // Extreme gains and limits; the upper threshold sits below the lower one.
        cfg_val[pdvi_pkg::CFG_KP]          = pdvi_pkg::S32_MAX;
        cfg_val[pdvi_pkg::CFG_KI]          = pdvi_pkg::S32_MIN;
        cfg_val[pdvi_pkg::CFG_KD]          = pdvi_pkg::S32_MIN;
        cfg_val[pdvi_pkg::CFG_DEAD_BAND]   = 0;
        cfg_val[pdvi_pkg::CFG_INTEG_LOWER] = 32'h7FFF_FFFF;
        cfg_val[pdvi_pkg::CFG_INTEG_UPPER] = 0;
        cfg_val[pdvi_pkg::CFG_INTEG_LIMIT] = 32'h7FFF_FFFF;
        cfg_val[pdvi_pkg::CFG_OUT_LIMIT]   = 32'h7FFF_FFFF;
        write_config();
        send_request(pdvi_pkg::S32_MAX, 0);
        send_request(pdvi_pkg::S32_MIN, 0);
        send_request(ONE, 0);
        send_request(0, pdvi_pkg::S32_MIN);
        settle();

        // Graded band across the whole range, so every step goes through the divider.
        cfg_val[pdvi_pkg::CFG_KP]          = -ONE;
        cfg_val[pdvi_pkg::CFG_KI]          = 3 * ONE;
        cfg_val[pdvi_pkg::CFG_KD]          = ONE;
        cfg_val[pdvi_pkg::CFG_INTEG_LOWER] = 0;
        cfg_val[pdvi_pkg::CFG_INTEG_UPPER] = 32'h7FFF_FFFF;
        cfg_val[pdvi_pkg::CFG_INTEG_LIMIT] = 1000 * ONE;
        write_config();
        send_request(20000 * ONE, -10000 * ONE);
        send_request(20000 * ONE, 0);
        send_request(-ONE, ONE);
        settle();

        while (random_sent < RANDOM_ITEMS) begin
            phase++;
            db = $urandom_range(0, ONE / 2);
            lo = $urandom_range(0, 4 * ONE);
            if ($urandom_range(0, 5) == 0) begin
                up = $urandom_range(0, lo);
            end else begin
                up = lo + $urandom_range(1, 16 * ONE);
            end
            case ($urandom_range(0, 5))
                0: il = 0;
                1: il = 32'h7FFF_FFFF;
                default: il = $urandom_range(0, 64 * ONE);
            endcase
            case ($urandom_range(0, 9))
                0: ol = 0;
                1: ol = 32'h7FFF_FFFF;
                default: ol = $urandom_range(ONE, 256 * ONE);
            endcase
            if ($urandom_range(0, 2) == 0) begin
                db = 0;
            end
            if ($urandom_range(0, 9) == 0) begin
                db = $urandom() >> 6;
                lo = $urandom();
                up = $urandom();
                il = $urandom();
            end
            cfg_val[pdvi_pkg::CFG_KP]          = rand_gain();
            cfg_val[pdvi_pkg::CFG_KI]          = rand_gain();
            cfg_val[pdvi_pkg::CFG_KD]          = rand_gain();
            cfg_val[pdvi_pkg::CFG_DEAD_BAND]   = db | ($urandom() & 32'h8000_0000);
            cfg_val[pdvi_pkg::CFG_INTEG_LOWER] = lo | ($urandom() & 32'h8000_0000);
            cfg_val[pdvi_pkg::CFG_INTEG_UPPER] = up | ($urandom() & 32'h8000_0000);
            cfg_val[pdvi_pkg::CFG_INTEG_LIMIT] = il | ($urandom() & 32'h8000_0000);
            cfg_val[pdvi_pkg::CFG_OUT_LIMIT]   = ol | ($urandom() & 32'h8000_0000);
            write_config();

            case ($urandom_range(0, 3))
                0: gap_max = 0;
                1: gap_max = 2;
                2: gap_max = 8;
                default: gap_max = 24;
            endcase
            // One phase keeps requests coming while the result side holds off for long.
            if (phase == 3) begin
                long_hold_req = 1'b1;
                gap_max = 0;
            end

            // Errors are spread around the thresholds so that all three zones are hit.
            span = (tracker.integ_upper > tracker.integ_lower) ? tracker.integ_upper
                                                               : tracker.integ_lower;
            span = span + span / 4 + ONE;
            if (span > 64'sd1073741824) begin
                span = 64'sd1073741824;
            end
            n_items = $urandom_range(60, 140);
            if (n_items > RANDOM_ITEMS - random_sent) begin
                n_items = RANDOM_ITEMS - random_sent;
            end
            repeat (n_items) begin
                mode = $urandom_range(0, 9);
                meas = $urandom();
                if (mode == 0) begin
                    tgt = $urandom();
                end else if (mode == 1) begin
                    tgt = $urandom_range(0, 1) ? pdvi_pkg::S32_MAX : pdvi_pkg::S32_MIN;
                end else begin
                    d = longint'($urandom_range(0, 32'(2 * span))) - span;
                    tgt = 32'(longint'($signed(meas)) + d);
                end
                send_request(tgt, meas);
                random_sent++;
            end
            settle();
        end

        if (tracker.pending_drive.size() != 0) begin
            $error("drive: %0d expected values never arrived", tracker.pending_drive.size());
            tracker.errors++;
        end
        $display("tb_top: %0d requests under %0d register settings, %0d drive values compared",
                 tracker.n_requests, settings, tracker.n_checked);
        $display("tb_top: %0d deadzone hits, %0d graded integral steps, %0d integral clears",
                 tracker.n_dead, tracker.n_graded, tracker.n_cleared);
        if (tracker.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
